/* rtl/relative_path_validator_core_assert.svh */
// assertion macros used by the checker file rpv_checker.sv
`ifndef RELATIVE_PATH_VALIDATOR_CORE_ASSERT_SVH
`define RELATIVE_PATH_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RPV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RPV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rpv_pkg.sv */
// ----------------------------------------------------------------------------
// rpv_pkg
// Types and codes shared by the relative path validator modules.
// ----------------------------------------------------------------------------
package rpv_pkg;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_EMPTY_COMP = 3'd2;
	localparam logic [2:0] ST_DOT_COMP   = 3'd3;
	localparam logic [2:0] ST_BACKSLASH  = 3'd4;
	localparam logic [2:0] ST_CONTROL    = 3'd5;
	localparam logic [2:0] ST_BAD_UTF8   = 3'd6;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// component kind tracked by the back end
	typedef enum logic [1:0] {
		KIND_EMPTY  = 2'd0,
		KIND_DOT    = 2'd1,
		KIND_DOTDOT = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	// narrowed continuation range after a lead byte
	typedef enum logic [1:0] {
		RNG_PLAIN = 2'd0,
		RNG_LOW   = 2'd1,
		RNG_HIGH  = 2'd2
	} range_t;

	typedef enum logic [2:0] {
		CLS_SLASH     = 3'd0,
		CLS_BACKSLASH = 3'd1,
		CLS_CONTROL   = 3'd2,
		CLS_DOT       = 3'd3,
		CLS_ASCII     = 3'd4,
		CLS_BAD_LEAD  = 3'd5,
		CLS_LEAD      = 3'd6
	} cls_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic       empty_path;
		logic       last_byte;
		cls_t       cls;
		logic [1:0] lead_pending;
		range_t     lead_range;
		logic       in_80_bf;
		logic       in_90_bf;
		logic       in_a0_bf;
		logic       in_80_8f;
		logic       in_80_9f;
	} rpv_item_t;

endpackage

/* rtl/rpv_fifo.sv */
// ----------------------------------------------------------------------------
// rpv_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rpv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/rpv_front.sv */
// ----------------------------------------------------------------------------
// rpv_front
// Byte classifier: sorts each path byte and precomputes utf-8 range tests.
// ----------------------------------------------------------------------------
module rpv_front import rpv_pkg::*; (
	input  logic [7:0] path_byte,
	input  logic       last_byte,
	input  logic       empty_path,
	output rpv_item_t  item
);
	always_comb begin
		item              = '0;
		item.empty_path   = empty_path;
		item.last_byte    = last_byte;
		item.lead_pending = 2'd0;
		item.lead_range   = RNG_PLAIN;
		item.in_80_bf     = (path_byte >= 8'h80) && (path_byte <= 8'hBF);
		item.in_90_bf     = (path_byte >= 8'h90) && (path_byte <= 8'hBF);
		item.in_a0_bf     = (path_byte >= 8'hA0) && (path_byte <= 8'hBF);
		item.in_80_8f     = (path_byte >= 8'h80) && (path_byte <= 8'h8F);
		item.in_80_9f     = (path_byte >= 8'h80) && (path_byte <= 8'h9F);

		if (path_byte == CH_SLASH) begin
			item.cls = CLS_SLASH;
		end else if (path_byte == CH_BACKSLASH) begin
			item.cls = CLS_BACKSLASH;
		end else if (path_byte < CH_SPACE) begin
			item.cls = CLS_CONTROL;
		end else if (path_byte == CH_DOT) begin
			item.cls = CLS_DOT;
		end else if (path_byte < 8'h80) begin
			item.cls = CLS_ASCII;
		end else if (path_byte < 8'hC2 || path_byte > 8'hF4) begin
			item.cls = CLS_BAD_LEAD;
		end else begin
			item.cls = CLS_LEAD;
			if (path_byte <= 8'hDF) begin
				item.lead_pending = 2'd1;
			end else if (path_byte <= 8'hEF) begin
				item.lead_pending = 2'd2;
				if (path_byte == 8'hE0) begin
					item.lead_range = RNG_LOW;
				end else if (path_byte == 8'hED) begin
					item.lead_range = RNG_HIGH;
				end
			end else begin
				item.lead_pending = 2'd3;
				if (path_byte == 8'hF0) begin
					item.lead_range = RNG_LOW;
				end else if (path_byte == 8'hF4) begin
					item.lead_range = RNG_HIGH;
				end
			end
		end
	end

endmodule

/* rtl/rpv_back.sv */
// ----------------------------------------------------------------------------
// rpv_back
// Per-path scanner: tracks components and utf-8 sequences, latches the
// first fault and emits one result at the end of each path.
// ----------------------------------------------------------------------------
module rpv_back import rpv_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rpv_item_t              item,
	input  logic                   item_valid,
	output logic                   item_take,
	input  logic                   res_full,
	output logic                   res_push,
	output logic [2:0]             res_status,
	output logic [OFFSET_BITS-1:0] res_offset
);
	localparam int OB = OFFSET_BITS;

	logic [OB-1:0] pos_q, comp_start_q, lead_pos_q, foff_q;
	kind_t         kind_q;
	logic [1:0]    pend_q;
	range_t        rng_q;
	logic [2:0]    fstat_q;

	logic [OB-1:0] pos_d, comp_start_d, lead_pos_d, foff_d;
	kind_t         kind_d;
	logic [1:0]    pend_d;
	range_t        rng_d;
	logic [2:0]    fstat_d;
	logic          cont_ok;
	logic          reset_path;

	function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] v);
		return (v == {OB{1'b1}}) ? v : v + 1'b1;
	endfunction

	assign item_take = item_valid && !res_full;
	assign res_push  = item_take && (item.empty_path || item.last_byte);

	always_comb begin
		case (rng_q)
			RNG_LOW:  cont_ok = (pend_q == 2'd3) ? item.in_90_bf : item.in_a0_bf;
			RNG_HIGH: cont_ok = (pend_q == 2'd3) ? item.in_80_8f : item.in_80_9f;
			default:  cont_ok = item.in_80_bf;
		endcase
	end

	always_comb begin
		pos_d        = pos_q;
		comp_start_d = comp_start_q;
		lead_pos_d   = lead_pos_q;
		foff_d       = foff_q;
		kind_d       = kind_q;
		pend_d       = pend_q;
		rng_d        = rng_q;
		fstat_d      = fstat_q;
		reset_path   = 1'b0;
		res_status   = ST_EMPTY;
		res_offset   = '0;

		if (item.empty_path) begin
			reset_path = 1'b1;
		end else begin
			if (fstat_q == ST_OK) begin
				if (pend_q != 2'd0) begin
					if (cont_ok) begin
						pend_d = pend_q - 1'b1;
						rng_d  = RNG_PLAIN;
					end else begin
						fstat_d = ST_BAD_UTF8;
						foff_d  = lead_pos_q;
					end
				end else begin
					case (item.cls)
						CLS_SLASH: begin
							if (kind_q == KIND_EMPTY) begin
								fstat_d = ST_EMPTY_COMP;
								foff_d  = comp_start_q;
							end else if (kind_q == KIND_DOT || kind_q == KIND_DOTDOT) begin
								fstat_d = ST_DOT_COMP;
								foff_d  = comp_start_q;
							end
							comp_start_d = sat_inc(pos_q);
							kind_d       = KIND_EMPTY;
						end
						CLS_BACKSLASH: begin
							fstat_d = ST_BACKSLASH;
							foff_d  = pos_q;
						end
						CLS_CONTROL: begin
							fstat_d = ST_CONTROL;
							foff_d  = pos_q;
						end
						CLS_DOT: begin
							if (kind_q == KIND_EMPTY) begin
								kind_d = KIND_DOT;
							end else if (kind_q == KIND_DOT) begin
								kind_d = KIND_DOTDOT;
							end else begin
								kind_d = KIND_OTHER;
							end
						end
						CLS_ASCII: begin
							kind_d = KIND_OTHER;
						end
						CLS_BAD_LEAD: begin
							fstat_d = ST_BAD_UTF8;
							foff_d  = pos_q;
						end
						CLS_LEAD: begin
							kind_d     = KIND_OTHER;
							pend_d     = item.lead_pending;
							rng_d      = item.lead_range;
							lead_pos_d = pos_q;
						end
						default: begin
							kind_d = KIND_OTHER;
						end
					endcase
				end
			end
			pos_d = sat_inc(pos_q);

			if (item.last_byte) begin
				reset_path = 1'b1;
				// end of path: open sequence or bad final component
				if (fstat_d == ST_OK) begin
					if (pend_d != 2'd0) begin
						fstat_d = ST_BAD_UTF8;
						foff_d  = lead_pos_d;
					end else if (kind_d == KIND_EMPTY) begin
						fstat_d = ST_EMPTY_COMP;
						foff_d  = comp_start_d;
					end else if (kind_d == KIND_DOT || kind_d == KIND_DOTDOT) begin
						fstat_d = ST_DOT_COMP;
						foff_d  = comp_start_d;
					end
				end
				res_status = fstat_d;
				res_offset = (fstat_d == ST_OK) ? '0 : foff_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			comp_start_q <= '0;
			lead_pos_q   <= '0;
			foff_q       <= '0;
			kind_q       <= KIND_EMPTY;
			pend_q       <= 2'd0;
			rng_q        <= RNG_PLAIN;
			fstat_q      <= ST_OK;
		end else if (item_take) begin
			if (reset_path) begin
				pos_q        <= '0;
				comp_start_q <= '0;
				lead_pos_q   <= '0;
				foff_q       <= '0;
				kind_q       <= KIND_EMPTY;
				pend_q       <= 2'd0;
				rng_q        <= RNG_PLAIN;
				fstat_q      <= ST_OK;
			end else begin
				pos_q        <= pos_d;
				comp_start_q <= comp_start_d;
				lead_pos_q   <= lead_pos_d;
				foff_q       <= foff_d;
				kind_q       <= kind_d;
				pend_q       <= pend_d;
				rng_q        <= rng_d;
				fstat_q      <= fstat_d;
			end
		end
	end

endmodule

/* rtl/relative_path_validator_core.sv */
// ----------------------------------------------------------------------------
// relative_path_validator_core
// Streaming relative path checker with strict utf-8 validation.
// ----------------------------------------------------------------------------
// Input side is a queue: drive path_byte, last_byte and empty_path with push;
// a transfer happens on a clock edge with push high and full low. One byte
// per transfer; last_byte marks the final byte of a path, and an item with
// empty_path set stands for a zero-length path.
// Result side is a queue too: while empty is low, status and error_offset show
// the oldest result; pop high at a clock edge transfers it. One result per
// path, given for its last byte or empty-path item.
// Throughput is one byte per cycle while the result queue is not full: the
// classifier writes a four-entry queue and the scanner takes one entry a
// cycle, with all per-path state updated as each entry is taken. From the last
// byte to empty going low, the byte is first written into the classify queue,
// and the scanner then writes its result into the result queue.
// When pop is held low the two-entry result queue fills, the scanner stops,
// the byte queue fills and full rises; nothing is dropped.
// Reset clears both queues and the per-path state; no clearing pass follows.
// ----------------------------------------------------------------------------
module relative_path_validator_core import rpv_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             path_byte,
	input  logic                   last_byte,
	input  logic                   empty_path,
	output logic                   empty,
	input  logic                   pop,
	output logic [2:0]             status,
	output logic [OFFSET_BITS-1:0] error_offset
);
	localparam int IW = $bits(rpv_item_t);
	localparam int RW = 3 + OFFSET_BITS;

	rpv_item_t              front_item, back_item;
	logic                   mid_empty, back_take;
	logic                   res_full, res_push;
	logic [2:0]             res_status;
	logic [OFFSET_BITS-1:0] res_offset;
	logic [RW-1:0]          res_head;

	rpv_front u_front (
		.path_byte  (path_byte),
		.last_byte  (last_byte),
		.empty_path (empty_path),
		.item       (front_item)
	);

	rpv_fifo #(.WIDTH(IW), .DEPTH(4)) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (back_take),
		.rdata  (back_item),
		.empty  (mid_empty)
	);

	rpv_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_valid (!mid_empty),
		.item_take  (back_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_status (res_status),
		.res_offset (res_offset)
	);

	rpv_fifo #(.WIDTH(RW), .DEPTH(2)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_status, res_offset}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign status       = res_head[RW-1 -: 3];
	assign error_offset = res_head[OFFSET_BITS-1:0];

endmodule

/* rtl/rpv_checker.sv */
// ----------------------------------------------------------------------------
// rpv_checker
// Port-level checks for relative_path_validator_core, bound to the top.
// ----------------------------------------------------------------------------
`include "relative_path_validator_core_assert.svh"

module rpv_checker import rpv_pkg::*; #(
	parameter int OFFSET_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   empty,
	input logic                   pop,
	input logic [2:0]             status,
	input logic [OFFSET_BITS-1:0] error_offset
);

	// a clean path reports offset zero
	`RPV_ASSERT_NOW(a_ok_offset_zero, !empty && status == ST_OK, error_offset == '0, "ok result with nonzero offset")

	// an empty path always reports offset zero
	`RPV_ASSERT_NOW(a_empty_offset_zero, !empty && status == ST_EMPTY, error_offset == '0, "empty-path result with nonzero offset")

	// a waiting result holds until it is transferred
	`RPV_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(status) && $stable(error_offset), "waiting result changed or vanished")

endmodule

bind relative_path_validator_core rpv_checker #(.OFFSET_BITS(OFFSET_BITS)) u_rpv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.status       (status),
	.error_offset (error_offset)
);
